// ===== src/grid_rect_first_fit_allocator_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the rectangle allocator
// Concurrent checks that drop out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef GRID_RECT_FIRST_FIT_ALLOCATOR_MACROS_SVH
`define GRID_RECT_FIRST_FIT_ALLOCATOR_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define GRFF_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("grff check failed");
// next-cycle implication
`define GRFF_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("grff check failed");
`else
`define GRFF_ASSERT_IMP(label, clk, rst, ante, cons)
`define GRFF_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== src/grff_pkg.sv =====
// ---------------------------------------------------------------------------
// grff_pkg
// Shared constants for the rectangle allocator.
// ---------------------------------------------------------------------------
`default_nettype none

package grff_pkg;

  localparam int DEF_MAX_ROWS    = 16;
  localparam int DEF_MAX_COLUMNS = 16;
  localparam int DEF_ID_BITS     = 8;

  localparam int CELL_BITS   = 8;
  localparam int OWNER_BITS  = 8;
  localparam int DIM_BITS    = 5;
  localparam int INDEX_BITS  = 8;

  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;

  localparam logic [DIM_BITS-1:0] DIM_RESET = 5'd16;

  // register select, taken from paddr[2]
  localparam logic REG_ROWS    = 1'b0;
  localparam logic REG_COLUMNS = 1'b1;

  localparam logic OP_PLACE = 1'b0;
  localparam logic OP_READ  = 1'b1;

endpackage

`default_nettype wire

// ===== src/grff_ram.sv =====
// ---------------------------------------------------------------------------
// grff_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module grff_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/grid_rect_first_fit_allocator.sv =====
// Read request: S_READ takes the cell read at accept; S_RESP loads the
// output register once free. Place request: a scan of up to rows*columns
// cells (one store read per cycle), then a width*height fill (one store
// write per cycle), then the output load. One request is in work at a
// time. Reset clears all MAX_ROWS*MAX_COLUMNS store cells in a sweep; no
// request is taken until it ends. Register writes are taken throughout.
// ---------------------------------------------------------------------------
// grid_rect_first_fit_allocator
// First-fit rectangle placement over an occupancy grid held in RAM.
// The scan keeps a horizontal run of empty cells and, per column, a count of
// stacked rows whose run reaches the width; the first bottom-right corner
// whose count reaches the height marks the first fitting position.
// ---------------------------------------------------------------------------
`default_nettype none

`include "grid_rect_first_fit_allocator_macros.svh"

module grid_rect_first_fit_allocator #(
  parameter int MAX_ROWS    = grff_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLUMNS = grff_pkg::DEF_MAX_COLUMNS,
  parameter int ID_BITS     = grff_pkg::DEF_ID_BITS
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [grff_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  wire logic [grff_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic      [grff_pkg::APB_DATA_BITS-1:0]   prdata,
  output logic                                      pready,
  input  wire logic                                 req_valid,
  output logic                                      req_ready,
  input  wire logic                                 op,
  input  wire logic [grff_pkg::OWNER_BITS-1:0]      owner_id,
  input  wire logic [grff_pkg::DIM_BITS-1:0]        rect_width,
  input  wire logic [grff_pkg::DIM_BITS-1:0]        rect_height,
  input  wire logic [grff_pkg::INDEX_BITS-1:0]      cell_index,
  output logic                                      rsp_valid,
  input  wire logic                                 rsp_ready,
  output logic                                      placed,
  output logic      [grff_pkg::INDEX_BITS-1:0]      top_left_index,
  output logic      [grff_pkg::OWNER_BITS-1:0]      cell_owner,
  output logic                                      index_ok
);

  import grff_pkg::*;

  localparam int DEPTH    = MAX_ROWS * MAX_COLUMNS;
  localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW       = $clog2(MAX_ROWS + 1);
  localparam int CW       = $clog2(MAX_COLUMNS + 1);
  localparam int COL_AW   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int CELLS_W  = $clog2(DEPTH + 1);
  localparam int CELL_W   = (ID_BITS < CELL_BITS) ? ID_BITS : CELL_BITS;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_READ  = 6'b000100,
    S_SCAN  = 6'b001000,
    S_FILL  = 6'b010000,
    S_RESP  = 6'b100000
  } state_t;

  state_t state;

  // configuration
  logic [DIM_BITS-1:0] grid_rows;
  logic [DIM_BITS-1:0] grid_columns;
  logic                cfg_we;

  logic [RW-1:0]         rows_eff;
  logic [CW-1:0]         cols_eff;
  logic [RW+CW-1:0]      cells_prod;
  logic [CELLS_W-1:0]    cells;

  // request
  logic [CELL_W-1:0] id_q;
  logic [CW-1:0]     w_q;
  logic [RW-1:0]     h_q;
  logic [CW-1:0]     row_step;
  logic              req_xfer;
  logic              place_fits;

  // scan issue side
  logic [ADDR_W-1:0] scan_addr;
  logic [COL_AW-1:0] scan_c;
  logic              scan_first;
  logic              scan_go;
  logic              scan_last;
  logic              scan_issue;

  // scan compute side, registered from the issue side
  logic              p_valid;
  logic [ADDR_W-1:0] p_addr;
  logic [COL_AW-1:0] p_c;
  logic              p_first;
  logic              p_last;
  logic [CW-1:0]     run;
  logic [CW-1:0]     run_next;
  logic [RW-1:0]     v_prev;
  logic [RW-1:0]     v_next;
  logic              row_ok;
  logic              hit;
  logic              fwd_valid;
  logic [COL_AW-1:0] fwd_c;
  logic [RW-1:0]     fwd_v;

  // fill
  logic [ADDR_W-1:0] fill_addr;
  logic [CW-1:0]     fc;
  logic [RW-1:0]     fr;

  // result
  logic                  res_placed;
  logic [INDEX_BITS-1:0] res_tl;
  logic [OWNER_BITS-1:0] res_owner;
  logic                  res_ok;
  logic                  out_free;

  // memories
  logic              st_we;
  logic [ADDR_W-1:0] st_addr;
  logic [CELL_W-1:0] st_wdata;
  logic [CELL_W-1:0] st_rdata;
  logic              v_we;
  logic [RW-1:0]     v_rdata;

  // ---------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows    <= DIM_RESET;
      grid_columns <= DIM_RESET;
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_ROWS:    grid_rows    <= pwdata[DIM_BITS-1:0];
        REG_COLUMNS: grid_columns <= pwdata[DIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_ROWS:    prdata = APB_DATA_BITS'(grid_rows);
      REG_COLUMNS: prdata = APB_DATA_BITS'(grid_columns);
      default:     prdata = '0;
    endcase
  end

  assign rows_eff = (32'(grid_rows) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(grid_rows);
  assign cols_eff = (32'(grid_columns) > MAX_COLUMNS) ? CW'(MAX_COLUMNS)
                                                      : CW'(grid_columns);
  assign cells_prod = {{CW{1'b0}}, rows_eff} * {{RW{1'b0}}, cols_eff};
  assign cells      = CELLS_W'(cells_prod);

  // ---------------------------------------------------------------------
  // request decode
  // ---------------------------------------------------------------------
  assign req_ready  = (state == S_IDLE);
  assign req_xfer   = req_valid & req_ready;
  assign place_fits = (rect_width != '0) && (rect_height != '0) &&
                      (32'(rect_width) <= 32'(cols_eff)) &&
                      (32'(rect_height) <= 32'(rows_eff));
  assign out_free   = !rsp_valid || rsp_ready;

  // ---------------------------------------------------------------------
  // scan datapath
  // ---------------------------------------------------------------------
  assign scan_issue = (state == S_SCAN) && scan_go;
  assign scan_last  = (32'(scan_addr) == 32'(cells) - 32'd1);

  always_comb begin
    run_next = '0;
    if (st_rdata == '0) begin
      if (p_c == '0) begin
        run_next = CW'(1);
      end else if (run == w_q) begin
        run_next = w_q;
      end else begin
        run_next = run + CW'(1);
      end
    end
    row_ok = (run_next == w_q);

    // first row starts from zero; with one column the last write is forwarded
    if (p_first) begin
      v_prev = '0;
    end else if (fwd_valid && (fwd_c == p_c)) begin
      v_prev = fwd_v;
    end else begin
      v_prev = v_rdata;
    end

    if (!row_ok) begin
      v_next = '0;
    end else if (v_prev == h_q) begin
      v_next = h_q;
    end else begin
      v_next = v_prev + RW'(1);
    end
    hit = (v_next == h_q);
  end

  assign v_we = (state == S_SCAN) && p_valid;

  // ---------------------------------------------------------------------
  // store port
  // ---------------------------------------------------------------------
  always_comb begin
    st_we    = 1'b0;
    st_addr  = scan_addr;
    st_wdata = id_q;
    unique case (state)
      S_CLEAR: begin
        st_we    = 1'b1;
        st_wdata = '0;
      end
      S_IDLE:  st_addr = ADDR_W'(cell_index);
      S_FILL: begin
        st_we   = 1'b1;
        st_addr = fill_addr;
      end
      default: ;
    endcase
  end

  grff_ram #(
    .WIDTH (CELL_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_addr),
    .wdata (st_wdata),
    .raddr (st_addr),
    .rdata (st_rdata)
  );

  grff_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_COLUMNS)
  ) u_stack (
    .clk   (clk),
    .we    (v_we),
    .waddr (p_c),
    .wdata (v_next),
    .raddr (scan_c),
    .rdata (v_rdata)
  );

  // ---------------------------------------------------------------------
  // control
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      scan_addr  <= '0;
      scan_go    <= 1'b0;
      p_valid    <= 1'b0;
      fwd_valid  <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (32'(scan_addr) == DEPTH - 1) begin
            state <= S_IDLE;
          end else begin
            scan_addr <= scan_addr + ADDR_W'(1);
          end
        end

        S_IDLE: begin
          if (req_xfer) begin
            res_placed <= 1'b0;
            res_tl     <= '0;
            res_owner  <= '0;
            res_ok     <= (op == OP_READ) && (32'(cell_index) < 32'(cells));
            if (op == OP_READ) begin
              state  <= S_READ;
            end else if (place_fits) begin
              id_q       <= owner_id[CELL_W-1:0];
              w_q        <= CW'(rect_width);
              h_q        <= RW'(rect_height);
              row_step   <= CW'(32'(cols_eff) - 32'(rect_width) + 32'd1);
              scan_addr  <= '0;
              scan_c     <= '0;
              scan_first <= 1'b1;
              scan_go    <= 1'b1;
              p_valid    <= 1'b0;
              fwd_valid  <= 1'b0;
              state      <= S_SCAN;
            end else begin
              state <= S_RESP;
            end
          end
        end

        S_READ: begin
          if (res_ok) begin
            res_owner <= OWNER_BITS'(st_rdata);
          end
          state <= S_RESP;
        end

        S_SCAN: begin
          // issue side; drop the pipeline once a corner is found
          p_valid <= scan_issue && !(p_valid && hit);
          p_addr  <= scan_addr;
          p_c     <= scan_c;
          p_first <= scan_first;
          p_last  <= scan_last;
          if ((scan_issue && scan_last) || (p_valid && hit)) begin
            scan_go <= 1'b0;
          end
          if (scan_issue) begin
            scan_addr <= scan_addr + ADDR_W'(1);
            if (32'(scan_c) == 32'(cols_eff) - 32'd1) begin
              scan_c     <= '0;
              scan_first <= 1'b0;
            end else begin
              scan_c <= scan_c + COL_AW'(1);
            end
          end
          // compute side
          if (p_valid) begin
            run       <= run_next;
            fwd_valid <= 1'b1;
            fwd_c     <= p_c;
            fwd_v     <= v_next;
            if (hit) begin
              // corner found: fill backward from the bottom-right cell
              fill_addr <= p_addr;
              fc        <= '0;
              fr        <= '0;
              state     <= S_FILL;
            end else if (p_last) begin
              state   <= S_RESP;
            end
          end
        end

        S_FILL: begin
          if (fc == w_q - CW'(1)) begin
            fc <= '0;
            if (fr == h_q - RW'(1)) begin
              res_placed <= 1'b1;
              res_tl     <= INDEX_BITS'(fill_addr);
              state      <= S_RESP;
            end else begin
              fr        <= fr + RW'(1);
              fill_addr <= fill_addr - ADDR_W'(row_step);
            end
          end else begin
            fc        <= fc + CW'(1);
            fill_addr <= fill_addr - ADDR_W'(1);
          end
        end

        S_RESP: begin
          if (out_free) begin
            state     <= S_IDLE;
          end
        end

        default: state <= S_CLEAR;
      endcase
    end
  end

  // response valid: set when a result is loaded, clear on its transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((state == S_RESP) && out_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // output register, loaded when the slot is free
  always_ff @(posedge clk) begin
    if ((state == S_RESP) && out_free) begin
      placed         <= res_placed;
      top_left_index <= res_tl;
      cell_owner     <= res_owner;
      index_ok       <= res_ok;
    end
  end

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------
`GRFF_ASSERT_IMP(a_fill_in_grid, clk, rst, state == S_FILL, 32'(fill_addr) < 32'(cells))
`GRFF_ASSERT_IMP(a_fill_cnt, clk, rst, state == S_FILL, (fc < w_q) && (fr < h_q))
`GRFF_ASSERT_IMP(a_pipe_in_scan, clk, rst, p_valid, state == S_SCAN)
`GRFF_ASSERT_NXT(a_xfer_busy, clk, rst, req_valid && req_ready, state != S_IDLE)

endmodule

`default_nettype wire

// ===== verif/tb_grid_rect_first_fit_allocator.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_grid_rect_first_fit_allocator
// Drives place and read requests into the rectangle allocator and keeps a
// shadow occupancy grid that predicts every response. Responses are checked
// field by field in order. Grid size changes go through the APB port when
// the block is idle. Both handshake sides idle and stall at random.
// ---------------------------------------------------------------------------

module tb_grid_rect_first_fit_allocator;

  localparam int GRID_MAX_ROWS    = grff_pkg::DEF_MAX_ROWS;
  localparam int GRID_MAX_COLUMNS = grff_pkg::DEF_MAX_COLUMNS;
  localparam int GRID_CELLS       = GRID_MAX_ROWS * GRID_MAX_COLUMNS;
  localparam int LONG_HOLD        = 1500;
  // slowest transfer gap: long hold plus a full scan and fill, taken many times
  localparam int QUIET_LIMIT      = 20000;
  localparam int TAIL_CYCLES      = 600;
  localparam int RANDOM_PHASES    = 10;
  localparam int PHASE_ITEMS      = 60;

  localparam logic [grff_pkg::APB_ADDR_BITS-1:0] ADDR_ROWS    = {grff_pkg::REG_ROWS, 2'b00};
  localparam logic [grff_pkg::APB_ADDR_BITS-1:0] ADDR_COLUMNS = {grff_pkg::REG_COLUMNS, 2'b00};

  typedef struct packed {
    logic                              op;
    logic [grff_pkg::OWNER_BITS-1:0]   owner_id;
    logic [grff_pkg::DIM_BITS-1:0]     rect_width;
    logic [grff_pkg::DIM_BITS-1:0]     rect_height;
    logic [grff_pkg::INDEX_BITS-1:0]   cell_index;
  } alloc_req_t;

  typedef struct packed {
    logic                              placed;
    logic [grff_pkg::INDEX_BITS-1:0]   top_left_index;
    logic [grff_pkg::OWNER_BITS-1:0]   cell_owner;
    logic                              index_ok;
  } alloc_rsp_t;

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite;
  logic [grff_pkg::APB_ADDR_BITS-1:0] paddr;
  logic [grff_pkg::APB_DATA_BITS-1:0] pwdata;
  logic [grff_pkg::APB_DATA_BITS-1:0] prdata;
  logic pready;
  logic req_valid, req_ready;
  logic op;
  logic [grff_pkg::OWNER_BITS-1:0] owner_id;
  logic [grff_pkg::DIM_BITS-1:0]   rect_width, rect_height;
  logic [grff_pkg::INDEX_BITS-1:0] cell_index;
  logic rsp_valid, rsp_ready;
  logic placed;
  logic [grff_pkg::INDEX_BITS-1:0] top_left_index;
  logic [grff_pkg::OWNER_BITS-1:0] cell_owner;
  logic index_ok;

  // shadow of the block state
  logic [grff_pkg::CELL_BITS-1:0] shadow_grid [GRID_CELLS];
  logic [grff_pkg::DIM_BITS-1:0]  shadow_rows;
  logic [grff_pkg::DIM_BITS-1:0]  shadow_columns;

  alloc_rsp_t pending_results [$];

  int  mismatch_count = 0;
  int  requests_sent  = 0;
  int  reads_sent     = 0;
  int  fits_predicted = 0;
  int  grid_settings  = 0;
  int  burst_left     = 0;
  int  quiet_cycles   = 0;
  bit  sender_gaps_on = 1'b1;
  bit  long_hold_req  = 1'b0;

  always #1 clk = ~clk;

  grid_rect_first_fit_allocator DUT (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .req_valid      (req_valid),
    .req_ready      (req_ready),
    .op             (op),
    .owner_id       (owner_id),
    .rect_width     (rect_width),
    .rect_height    (rect_height),
    .cell_index     (cell_index),
    .rsp_valid      (rsp_valid),
    .rsp_ready      (rsp_ready),
    .placed         (placed),
    .top_left_index (top_left_index),
    .cell_owner     (cell_owner),
    .index_ok       (index_ok)
  );

  function automatic int rows_in_use();
    return (shadow_rows > GRID_MAX_ROWS) ? GRID_MAX_ROWS : int'(shadow_rows);
  endfunction

  function automatic int columns_in_use();
    return (shadow_columns > GRID_MAX_COLUMNS) ? GRID_MAX_COLUMNS : int'(shadow_columns);
  endfunction

  // First-fit placement or cell read against the shadow grid.
  function automatic alloc_rsp_t predict_allocation(alloc_req_t rq);
    alloc_rsp_t rs;
    int rows, cols, w, h, r, c, rr, cc;
    bit found, clear;
    rs    = '0;
    rows  = rows_in_use();
    cols  = columns_in_use();
    w     = rq.rect_width;
    h     = rq.rect_height;
    found = 1'b0;
    if (rq.op == grff_pkg::OP_PLACE) begin
      if (w != 0 && h != 0 && w <= cols && h <= rows) begin
        for (r = 0; r + h <= rows && !found; r++) begin
          for (c = 0; c + w <= cols && !found; c++) begin
            clear = 1'b1;
            for (rr = r; rr < r + h; rr++)
              for (cc = c; cc < c + w; cc++)
                if (shadow_grid[rr * cols + cc] != '0) clear = 1'b0;
            if (clear) begin
              for (rr = r; rr < r + h; rr++)
                for (cc = c; cc < c + w; cc++)
                  shadow_grid[rr * cols + cc] = rq.owner_id;
              rs.placed         = 1'b1;
              rs.top_left_index = grff_pkg::INDEX_BITS'(r * cols + c);
              found             = 1'b1;
            end
          end
        end
      end
    end else if (rq.cell_index < rows * cols) begin
      rs.index_ok   = 1'b1;
      rs.cell_owner = shadow_grid[rq.cell_index];
    end
    return rs;
  endfunction

  function automatic alloc_req_t random_request();
    alloc_req_t rq;
    int rows, cols, pick;
    rows           = rows_in_use();
    cols           = columns_in_use();
    rq.owner_id    = 8'($urandom_range(0, 255));
    rq.rect_width  = 5'($urandom_range(0, 31));
    rq.rect_height = 5'($urandom_range(0, 31));
    rq.cell_index  = 8'($urandom_range(0, 255));
    rq.op          = ($urandom_range(0, 99) < 45) ? grff_pkg::OP_READ : grff_pkg::OP_PLACE;
    if (rq.op == grff_pkg::OP_READ) begin
      if (rows * cols > 0 && $urandom_range(0, 4) != 0)
        rq.cell_index = 8'($urandom_range(0, rows * cols - 1));
    end else begin
      pick = $urandom_range(0, 99);
      // mostly small rectangles so the grid does not fill too early
      if (pick < 60) begin
        rq.rect_width  = 5'($urandom_range(1, 3));
        rq.rect_height = 5'($urandom_range(1, 3));
      end else if (pick < 85 && rows > 0 && cols > 0) begin
        rq.rect_width  = 5'($urandom_range(1, cols));
        rq.rect_height = 5'($urandom_range(1, rows));
      end
      if ($urandom_range(0, 3) == 0) rq.owner_id = '0;
    end
    return rq;
  endfunction

  // Offer one request, honoring the burst/gap pattern, and log its predicted response.
  task automatic send_request(input alloc_req_t rq);
    int gap;
    @(negedge clk);
    if (sender_gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    req_valid   <= 1'b1;
    op          <= rq.op;
    owner_id    <= rq.owner_id;
    rect_width  <= rq.rect_width;
    rect_height <= rq.rect_height;
    cell_index  <= rq.cell_index;
    do @(posedge clk); while (!req_ready);
    pending_results.push_back(predict_allocation(rq));
    requests_sent++;
    if (rq.op == grff_pkg::OP_READ) reads_sent++;
    else if (pending_results[$].placed) fits_predicted++;
  endtask

  task automatic place_rect(input logic [7:0] id, input logic [4:0] w, input logic [4:0] h);
    alloc_req_t rq;
    rq.op          = grff_pkg::OP_PLACE;
    rq.owner_id    = id;
    rq.rect_width  = w;
    rq.rect_height = h;
    rq.cell_index  = 8'($urandom_range(0, 255));
    send_request(rq);
  endtask

  task automatic read_cell(input logic [7:0] idx);
    alloc_req_t rq;
    rq.op          = grff_pkg::OP_READ;
    rq.owner_id    = 8'($urandom_range(0, 255));
    rq.rect_width  = 5'($urandom_range(0, 31));
    rq.rect_height = 5'($urandom_range(0, 31));
    rq.cell_index  = idx;
    send_request(rq);
  endtask

  // Drop valid and hold until every logged response has come back.
  task automatic wait_for_results();
    @(negedge clk);
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [grff_pkg::APB_ADDR_BITS-1:0] addr,
                           input logic [grff_pkg::DIM_BITS-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {{(grff_pkg::APB_DATA_BITS - grff_pkg::DIM_BITS){1'b0}}, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_ROWS) shadow_rows = value;
    else shadow_columns = value;
  endtask

  task automatic set_grid(input logic [4:0] rows, input logic [4:0] cols);
    wait_for_results();
    write_reg(ADDR_ROWS, rows);
    write_reg(ADDR_COLUMNS, cols);
    grid_settings++;
  endtask

  task automatic test_reset_state();
    read_cell(8'd0);
    read_cell(8'd255);
    read_cell(8'd170);
  endtask

  task automatic test_place_special();
    place_rect(8'h00, 5'd16, 5'd16);   // empty id: fits but leaves cells empty
    place_rect(8'h05, 5'd0, 5'd1);
    place_rect(8'h05, 5'd1, 5'd0);
    place_rect(8'hFF, 5'd31, 5'd1);
    place_rect(8'hAA, 5'd1, 5'd31);
  endtask

  task automatic test_first_fit();
    place_rect(8'h01, 5'd16, 5'd1);
    place_rect(8'h80, 5'd2, 5'd2);
    place_rect(8'h55, 5'd3, 5'd1);
    read_cell(8'd17);
    read_cell(8'd18);
    read_cell(8'd0);
    place_rect(8'h7F, 5'd16, 5'd16);
    place_rect(8'hFE, 5'd1, 5'd1);
  endtask

  task automatic test_register_extremes();
    set_grid(5'd0, 5'd16);
    place_rect(8'h11, 5'd1, 5'd1);
    read_cell(8'd0);
    set_grid(5'd31, 5'd31);
    place_rect(8'h22, 5'd1, 5'd1);
    read_cell(8'd255);
    set_grid(5'd1, 5'd1);
    read_cell(8'd0);
    read_cell(8'd1);
    place_rect(8'h33, 5'd1, 5'd1);
    set_grid(5'd16, 5'd4);
    read_cell(8'd4);
    set_grid(5'd16, 5'd16);
  endtask

  task automatic test_random_traffic();
    logic [4:0] rows_plan [4];
    logic [4:0] cols_plan [4];
    int p, i;
    rows_plan = '{5'd16, 5'd1, 5'd31, 5'd8};
    cols_plan = '{5'd16, 5'd31, 5'd1, 5'd8};
    for (p = 0; p < RANDOM_PHASES; p++) begin
      if (p < 4) set_grid(rows_plan[p], cols_plan[p]);
      else set_grid(5'($urandom_range(1, 31)), 5'($urandom_range(1, 31)));
      for (i = 0; i < PHASE_ITEMS; i++) send_request(random_request());
    end
  endtask

  task automatic test_output_backpressure();
    int i;
    wait_for_results();
    sender_gaps_on = 1'b0;
    long_hold_req  = 1'b1;
    for (i = 0; i < 30; i++) send_request(random_request());
    sender_gaps_on = 1'b1;
  endtask

  task automatic test_drain_pause();
    int i;
    for (i = 0; i < 20; i++) send_request(random_request());
    wait_for_results();
    for (i = 0; i < 20; i++) send_request(random_request());
  endtask

  // Receiver: random ready pattern, plus one long hold-off on request.
  initial begin : receiver
    int run_left, mode, hold_left;
    rsp_ready = 1'b0;
    run_left  = 0;
    mode      = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else begin
        if (run_left == 0) begin
          mode     = $urandom_range(0, 2);
          run_left = $urandom_range(10, 150);
        end
        run_left--;
        case (mode)
          0: rsp_ready <= 1'b1;
          1: rsp_ready <= ($urandom_range(0, 1) == 1);
          default: rsp_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Compare each response transfer with the oldest prediction.
  always @(posedge clk) begin
    alloc_rsp_t exp_rsp;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_results.size() == 0) begin
        $error("response with no request outstanding");
        mismatch_count++;
      end else begin
        exp_rsp = pending_results.pop_front();
        if (placed !== exp_rsp.placed) begin
          $error("placed: expected %0d, got %0d", exp_rsp.placed, placed);
          mismatch_count++;
        end
        if (top_left_index !== exp_rsp.top_left_index) begin
          $error("top_left_index: expected %0d, got %0d", exp_rsp.top_left_index,
                 top_left_index);
          mismatch_count++;
        end
        if (cell_owner !== exp_rsp.cell_owner) begin
          $error("cell_owner: expected %0d, got %0d", exp_rsp.cell_owner, cell_owner);
          mismatch_count++;
        end
        if (index_ok !== exp_rsp.index_ok) begin
          $error("index_ok: expected %0d, got %0d", exp_rsp.index_ok, index_ok);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
      $display("grid_rect_first_fit_allocator: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst            = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    req_valid      = 1'b0;
    op             = grff_pkg::OP_PLACE;
    owner_id       = '0;
    rect_width     = '0;
    rect_height    = '0;
    cell_index     = '0;
    shadow_rows    = grff_pkg::DIM_RESET;
    shadow_columns = grff_pkg::DIM_RESET;
    foreach (shadow_grid[i]) shadow_grid[i] = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_place_special();
    test_first_fit();
    test_register_extremes();
    test_random_traffic();
    test_output_backpressure();
    test_drain_pause();

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d requests: %0d reads, %0d successful placements, %0d grid sizes.",
             requests_sent, reads_sent, fits_predicted, grid_settings);
    $display("Included a %0d-cycle output hold-off and a full drain pause.", LONG_HOLD);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("grid_rect_first_fit_allocator: match");
    end else begin
      $display("grid_rect_first_fit_allocator: mismatch");
    end
    $finish;
  end

endmodule
